// ----- sv/cdt_pkg.sv -----
// Shared types, opcodes and constants for the countdown timer controller.
`timescale 1ns / 1ps

package cdt_pkg;

    localparam int REM_W    = 27;
    localparam int PRESET_W = 17;
    localparam int TIME_W   = 32;

    // Event opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESET   = 3'd2;
    localparam logic [2:0] OP_SETTING = 3'd3;
    localparam logic [2:0] OP_HAT     = 3'd4;

    // Focus codes
    localparam logic [1:0] FOCUS_OFF     = 2'd0;
    localparam logic [1:0] FOCUS_HOURS   = 2'd1;
    localparam logic [1:0] FOCUS_MINUTES = 2'd2;
    localparam logic [1:0] FOCUS_SECONDS = 2'd3;

    // Hat bit positions
    localparam int HAT_UP    = 0;
    localparam int HAT_RIGHT = 1;
    localparam int HAT_DOWN  = 2;
    localparam int HAT_LEFT  = 3;

    localparam logic [PRESET_W-1:0] PRESET_MAX   = 17'd86399;
    localparam logic [PRESET_W-1:0] PRESET_RESET = 17'd300;
    localparam logic [PRESET_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [PRESET_W-1:0] SEC_PER_MIN  = 17'd60;
    localparam logic [REM_W-1:0]    MS_PER_SEC   = 27'd1000;
    localparam logic [REM_W-1:0]    HALF_SEC_MS  = 27'd500;

    // Reciprocals for division by constants: floor(x / d) = (x * RECIP) >> SHIFT
    localparam logic [27:0] RECIP_MS     = 28'd137438953; // 2^37 / 1000, rounded down
    localparam int          SHIFT_MS     = 37;
    localparam logic [17:0] RECIP_MIN    = 18'd139811;    // 2^23 / 60, rounded up
    localparam int          SHIFT_MIN    = 23;
    localparam logic [12:0] RECIP_HOUR   = 13'd4370;      // 2^18 / 60, rounded up
    localparam int          SHIFT_HOUR   = 18;

    // Status after one event, carried down the display pipeline
    typedef struct packed {
        logic                running;
        logic                alarm;
        logic [1:0]          focus;
        logic [REM_W-1:0]    remaining;
        logic                use_rem;   // show the remaining time, else the preset
        logic [PRESET_W-1:0] preset;
    } t_status;

endpackage

// ----- sv/cdt_core.sv -----
// Event register and timer state update for the countdown timer controller.
`timescale 1ns / 1ps

module cdt_core import cdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [2:0]        i_op,
    input  logic [3:0]        i_hat,
    input  logic [TIME_W-1:0] i_now,
    output logic              o_vld,
    input  logic              i_rdy,
    output t_status           o_status
);

    logic              r_a_vld;
    logic [2:0]        r_a_op;
    logic [3:0]        r_a_hat;
    logic [TIME_W-1:0] r_a_now;

    logic              r_b_vld;
    t_status           r_b_status;

    logic [REM_W-1:0]    r_rem,     n_rem;
    logic [TIME_W-1:0]   r_last,    n_last;
    logic [PRESET_W-1:0] r_preset,  n_preset;
    logic                r_running, n_running;
    logic                r_alarm,   n_alarm;
    logic [1:0]          r_focus,   n_focus;

    logic                a_rdy;
    logic                b_rdy;
    logic [TIME_W-1:0]   elapsed;
    logic                el_ge;
    logic [REM_W-1:0]    rem_sub;
    logic [REM_W-1:0]    load_ms;
    logic [PRESET_W-1:0] step;
    logic [PRESET_W:0]   preset_up;
    t_status             status;

    assign b_rdy = !r_b_vld || i_rdy;
    assign a_rdy = !r_a_vld || b_rdy;
    assign o_rdy = a_rdy;

    assign elapsed = r_a_now - r_last;
    assign el_ge   = elapsed >= {{(TIME_W-REM_W){1'b0}}, r_rem};
    assign rem_sub = r_rem - elapsed[REM_W-1:0];
    assign load_ms = REM_W'({{(REM_W-PRESET_W){1'b0}}, r_preset} * MS_PER_SEC);

    always_comb begin
        case (r_focus)
            FOCUS_HOURS:   step = SEC_PER_HOUR;
            FOCUS_MINUTES: step = SEC_PER_MIN;
            default:       step = PRESET_W'(1);
        endcase
    end

    assign preset_up = {1'b0, r_preset} + {1'b0, step};

    always_comb begin
        n_rem     = r_rem;
        n_last    = r_last;
        n_preset  = r_preset;
        n_running = r_running;
        n_alarm   = r_alarm;
        n_focus   = r_focus;
        // A pending alarm swallows the next button press.
        if (r_alarm && (r_a_op inside {OP_START, OP_RESET, OP_SETTING})) begin
            n_alarm   = 1'b0;
            n_running = 1'b0;
            n_rem     = '0;
        end else begin
            case (r_a_op)
                OP_TICK: begin
                    if (r_running) begin
                        if (el_ge) begin
                            n_rem     = '0;
                            n_running = 1'b0;
                            n_alarm   = 1'b1;
                        end else begin
                            n_rem  = rem_sub;
                            n_last = r_a_now;
                        end
                    end
                end
                OP_START: begin
                    if (!r_running) begin
                        if (r_rem == '0) begin
                            n_rem = load_ms;
                        end
                        n_last    = r_a_now;
                        n_running = 1'b1;
                    end else begin
                        n_running = 1'b0;
                        n_rem     = el_ge ? '0 : rem_sub;
                    end
                end
                OP_RESET: begin
                    n_running = 1'b0;
                    n_rem     = '0;
                end
                OP_SETTING: begin
                    if (!r_running) begin
                        if (r_focus == FOCUS_OFF) begin
                            n_focus = FOCUS_HOURS;
                            n_rem   = '0;
                        end else begin
                            n_focus = FOCUS_OFF;
                        end
                    end
                end
                OP_HAT: begin
                    if (r_focus != FOCUS_OFF && !r_running) begin
                        if (r_a_hat[HAT_UP]) begin
                            n_preset = (preset_up > {1'b0, PRESET_MAX}) ? PRESET_MAX
                                                                        : preset_up[PRESET_W-1:0];
                        end
                        if (r_a_hat[HAT_DOWN]) begin
                            n_preset = (n_preset >= step) ? n_preset - step : '0;
                        end
                        // Right then left; left sees the focus that right left.
                        if (r_a_hat[HAT_RIGHT]) begin
                            if (n_focus == FOCUS_HOURS) begin
                                n_focus = FOCUS_MINUTES;
                            end else if (n_focus == FOCUS_MINUTES) begin
                                n_focus = FOCUS_SECONDS;
                            end
                        end
                        if (r_a_hat[HAT_LEFT]) begin
                            if (n_focus == FOCUS_SECONDS) begin
                                n_focus = FOCUS_MINUTES;
                            end else if (n_focus == FOCUS_MINUTES) begin
                                n_focus = FOCUS_HOURS;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        status.running   = n_running;
        status.alarm     = n_alarm;
        status.focus     = n_focus;
        status.remaining = n_rem;
        status.use_rem   = n_running || (n_rem != '0);
        status.preset    = n_preset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_rem     <= '0;
            r_last    <= '0;
            r_preset  <= PRESET_RESET;
            r_running <= 1'b0;
            r_alarm   <= 1'b0;
            r_focus   <= FOCUS_OFF;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_vld;
            end
            if (b_rdy) begin
                r_b_vld <= r_a_vld;
            end
            if (r_a_vld && b_rdy) begin
                r_rem     <= n_rem;
                r_last    <= n_last;
                r_preset  <= n_preset;
                r_running <= n_running;
                r_alarm   <= n_alarm;
                r_focus   <= n_focus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && a_rdy) begin
            r_a_op  <= i_op;
            r_a_hat <= i_hat;
            r_a_now <= i_now;
        end
        if (r_a_vld && b_rdy) begin
            r_b_status <= status;
        end
    end

    assign o_vld    = r_b_vld;
    assign o_status = r_b_status;

endmodule

// ----- sv/cdt_disp.sv -----
// Display pipeline: rounds the remaining time and splits it into hours, minutes, seconds.
`timescale 1ns / 1ps

module cdt_disp import cdt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    output logic       o_rdy,
    input  t_status    i_status,
    output logic       o_vld,
    input  logic       i_rdy,
    output logic [47:0] o_tdata  // is_running, alarm_flag, focus_field[1:0],
                                 // remaining_ms[26:0], show_hours[4:0],
                                 // show_minutes[5:0], show_seconds[5:0]
);

    // Stage C: rounded milliseconds times the reciprocal of 1000
    logic                r_c_vld;
    t_status             r_c_st;
    logic [REM_W-1:0]    r_c_x;
    logic [PRESET_W-1:0] r_c_q;
    // Stage D: corrected quotient, selected display seconds
    logic                r_d_vld;
    t_status             r_d_st;
    logic [PRESET_W-1:0] r_d_disp;
    // Stage E: total minutes
    logic                r_e_vld;
    t_status             r_e_st;
    logic [PRESET_W-1:0] r_e_disp;
    logic [10:0]         r_e_tm;
    // Stage F: hours and seconds
    logic                r_f_vld;
    t_status             r_f_st;
    logic [10:0]         r_f_tm;
    logic [4:0]          r_f_hr;
    logic [5:0]          r_f_sec;
    // Stage G: output word
    logic                r_g_vld;
    t_status             r_g_st;
    logic [4:0]          r_g_hr;
    logic [5:0]          r_g_min;
    logic [5:0]          r_g_sec;

    logic c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;

    logic [REM_W-1:0]    c_x;
    logic [54:0]         c_prod;
    logic [REM_W-1:0]    d_rest;
    logic [PRESET_W-1:0] d_q;
    logic [34:0]         e_prod;
    logic [23:0]         f_prod;
    logic [PRESET_W-1:0] f_sec;
    logic [10:0]         g_min;

    assign g_rdy = !r_g_vld || i_rdy;
    assign f_rdy = !r_f_vld || g_rdy;
    assign e_rdy = !r_e_vld || f_rdy;
    assign d_rdy = !r_d_vld || e_rdy;
    assign c_rdy = !r_c_vld || d_rdy;
    assign o_rdy = c_rdy;

    assign c_x    = i_status.remaining + HALF_SEC_MS;
    assign c_prod = 55'(c_x) * 55'(RECIP_MS);

    // The estimate can fall one short of the true quotient.
    assign d_rest = r_c_x - REM_W'({{(REM_W-PRESET_W){1'b0}}, r_c_q} * MS_PER_SEC);
    assign d_q    = (d_rest >= MS_PER_SEC) ? r_c_q + PRESET_W'(1) : r_c_q;

    assign e_prod = 35'(r_d_disp) * 35'(RECIP_MIN);

    assign f_prod = 24'(r_e_tm) * 24'(RECIP_HOUR);
    assign f_sec  = r_e_disp - PRESET_W'({6'd0, r_e_tm} * SEC_PER_MIN);

    assign g_min  = r_f_tm - 11'({6'd0, r_f_hr} * SEC_PER_MIN[5:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            if (c_rdy) r_c_vld <= i_vld;
            if (d_rdy) r_d_vld <= r_c_vld;
            if (e_rdy) r_e_vld <= r_d_vld;
            if (f_rdy) r_f_vld <= r_e_vld;
            if (g_rdy) r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && c_rdy) begin
            r_c_st <= i_status;
            r_c_x  <= c_x;
            r_c_q  <= c_prod[SHIFT_MS+PRESET_W-1:SHIFT_MS];
        end
        if (r_c_vld && d_rdy) begin
            r_d_st   <= r_c_st;
            r_d_disp <= r_c_st.use_rem ? d_q : r_c_st.preset;
        end
        if (r_d_vld && e_rdy) begin
            r_e_st   <= r_d_st;
            r_e_disp <= r_d_disp;
            r_e_tm   <= e_prod[SHIFT_MIN+10:SHIFT_MIN];
        end
        if (r_e_vld && f_rdy) begin
            r_f_st  <= r_e_st;
            r_f_tm  <= r_e_tm;
            r_f_hr  <= f_prod[SHIFT_HOUR+4:SHIFT_HOUR];
            r_f_sec <= f_sec[5:0];
        end
        if (r_f_vld && g_rdy) begin
            r_g_st  <= r_f_st;
            r_g_hr  <= r_f_hr;
            r_g_min <= g_min[5:0];
            r_g_sec <= r_f_sec;
        end
    end

    assign o_vld   = r_g_vld;
    assign o_tdata = {r_g_sec, r_g_min, r_g_hr, r_g_st.remaining,
                      r_g_st.focus, r_g_st.alarm, r_g_st.running};

endmodule

// ----- sv/countdown_timer_controller.sv -----
// Top level of the hours:minutes:seconds countdown timer controller.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one event word per handshake: tuser carries the
// opcode (tick, start/pause, reset, setting toggle, hat motion) and tdata the
// hat bits and the free-running millisecond clock. Every event word yields
// exactly one status word on the master channel: run and alarm flags, focus,
// remaining milliseconds and the displayed hours, minutes and seconds.
// The event word is registered first, and the timer state is then updated from
// it as the status register takes its word; the display value then passes a
// five-stage divide-by-constant pipeline on its way to the master channel.
// One word is accepted and one produced per cycle while the master side keeps
// tready high; the state update is the only loop.
// Every stage has its own register, so a stalled master side fills the
// pipeline word by word before tready drops on the slave side; no word is
// lost or repeated. Reset empties the pipeline, stops the countdown, clears
// the remaining time, alarm and focus, and loads a preset of 300 seconds.
module countdown_timer_controller import cdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // hat_bits[3:0], now_ms[35:4], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // opcode[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // is_running[0], alarm_flag[1],
                                          // focus_field[3:2], remaining_ms[30:4],
                                          // show_hours[35:31], show_minutes[41:36],
                                          // show_seconds[47:42]
);

    logic    core_vld;
    logic    disp_rdy;
    t_status core_status;

    cdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_s_axis_tvalid),
        .o_rdy    (o_s_axis_tready),
        .i_op     (i_s_axis_tuser),
        .i_hat    (i_s_axis_tdata[3:0]),
        .i_now    (i_s_axis_tdata[35:4]),
        .o_vld    (core_vld),
        .i_rdy    (disp_rdy),
        .o_status (core_status)
    );

    cdt_disp u_disp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (core_vld),
        .o_rdy    (disp_rdy),
        .i_status (core_status),
        .o_vld    (o_m_axis_tvalid),
        .i_rdy    (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

// ----- verif/tb_countdown_timer_controller.sv -----
// Self-checking testbench for the countdown timer controller.
`timescale 1ns / 1ps

module tb_countdown_timer_controller;
    import cdt_pkg::*;

    // Opcodes with no action; the block still answers them with a status word.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                running;
        logic                alarm;
        logic [1:0]          focus;
        logic [REM_W-1:0]    remaining;
        logic [4:0]          hours;
        logic [5:0]          minutes;
        logic [5:0]          seconds;
    } t_status_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Timer state as the testbench expects it to be
    logic [REM_W-1:0]    tm_remaining;
    logic [TIME_W-1:0]   tm_last_tick;
    logic [PRESET_W-1:0] tm_preset;
    logic                tm_running;
    logic                tm_alarm;
    logic [1:0]          tm_focus;

    t_status_word expected_status[$];
    logic [31:0]  clock_ms = '0;
    int unsigned  events_sent = 0;
    int unsigned  words_checked = 0;
    int unsigned  error_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_cycles = 0;

    countdown_timer_controller dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_timer_state();
        tm_remaining = '0;
        tm_last_tick = '0;
        tm_preset    = PRESET_RESET;
        tm_running   = 1'b0;
        tm_alarm     = 1'b0;
        tm_focus     = FOCUS_OFF;
    endfunction

    // Applies one event to the expected timer state and returns the status it should produce.
    function automatic t_status_word apply_timer_event(input logic [2:0] op,
                                                       input logic [3:0] hat,
                                                       input logic [31:0] now);
        logic [31:0]  elapsed;
        int unsigned  step;
        int unsigned  raised;
        int unsigned  shown;
        t_status_word st;
        elapsed = now - tm_last_tick;
        if (tm_alarm && (op == OP_START || op == OP_RESET || op == OP_SETTING)) begin
            // A button only dismisses the alarm.
            tm_alarm     = 1'b0;
            tm_running   = 1'b0;
            tm_remaining = '0;
        end else begin
            case (op)
                OP_TICK: begin
                    if (tm_running) begin
                        if (elapsed >= 32'(tm_remaining)) begin
                            tm_remaining = '0;
                            tm_running   = 1'b0;
                            tm_alarm     = 1'b1;
                        end else begin
                            tm_remaining = tm_remaining - elapsed[REM_W-1:0];
                            tm_last_tick = now;
                        end
                    end
                end
                OP_START: begin
                    if (!tm_running) begin
                        if (tm_remaining == '0)
                            tm_remaining = tm_preset * MS_PER_SEC;
                        tm_last_tick = now;
                        tm_running   = 1'b1;
                    end else begin
                        // Pausing past zero stops at zero without an alarm.
                        tm_running   = 1'b0;
                        tm_remaining = (elapsed >= 32'(tm_remaining)) ? '0
                                     : tm_remaining - elapsed[REM_W-1:0];
                    end
                end
                OP_RESET: begin
                    tm_running   = 1'b0;
                    tm_remaining = '0;
                end
                OP_SETTING: begin
                    if (!tm_running) begin
                        tm_focus = (tm_focus == FOCUS_OFF) ? FOCUS_HOURS : FOCUS_OFF;
                        if (tm_focus != FOCUS_OFF)
                            tm_remaining = '0;
                    end
                end
                OP_HAT: begin
                    if (tm_focus != FOCUS_OFF && !tm_running) begin
                        step = (tm_focus == FOCUS_HOURS) ? SEC_PER_HOUR
                             : (tm_focus == FOCUS_MINUTES) ? SEC_PER_MIN : 1;
                        if (hat[HAT_UP]) begin
                            raised = tm_preset + step;
                            tm_preset = (raised > PRESET_MAX) ? PRESET_MAX
                                                              : raised[PRESET_W-1:0];
                        end
                        if (hat[HAT_DOWN])
                            tm_preset = (tm_preset >= step) ? PRESET_W'(tm_preset - step)
                                                            : '0;
                        if (hat[HAT_RIGHT]) begin
                            if (tm_focus == FOCUS_HOURS)
                                tm_focus = FOCUS_MINUTES;
                            else if (tm_focus == FOCUS_MINUTES)
                                tm_focus = FOCUS_SECONDS;
                        end
                        if (hat[HAT_LEFT]) begin
                            if (tm_focus == FOCUS_SECONDS)
                                tm_focus = FOCUS_MINUTES;
                            else if (tm_focus == FOCUS_MINUTES)
                                tm_focus = FOCUS_HOURS;
                        end
                    end
                end
                default: ;
            endcase
        end
        shown = (tm_running || tm_remaining != '0)
              ? (32'(tm_remaining) + 32'(HALF_SEC_MS)) / 32'(MS_PER_SEC)
              : 32'(tm_preset);
        st.running   = tm_running;
        st.alarm     = tm_alarm;
        st.focus     = tm_focus;
        st.remaining = tm_remaining;
        st.hours     = 5'(shown / SEC_PER_HOUR);
        st.minutes   = 6'((shown % SEC_PER_HOUR) / SEC_PER_MIN);
        st.seconds   = 6'(shown % SEC_PER_MIN);
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("status word %0d, %s = %0d, expected %0d",
                                      words_checked, name, got, want));
    endtask

    task automatic check_status_word(input logic [47:0] word);
        t_status_word want;
        if (expected_status.size() == 0) begin
            report_mismatch($sformatf("status word %h arrived with none expected", word));
        end else begin
            want = expected_status.pop_front();
            check_field("is_running",   word[0],     want.running);
            check_field("alarm_flag",   word[1],     want.alarm);
            check_field("focus_field",  word[3:2],   want.focus);
            check_field("remaining_ms", word[30:4],  want.remaining);
            check_field("show_hours",   word[35:31], want.hours);
            check_field("show_minutes", word[41:36], want.minutes);
            check_field("show_seconds", word[47:42], want.seconds);
        end
        words_checked++;
    endtask

    // Output side: checks each accepted word, then decides tready for the next cycle.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            check_status_word(m_tdata);
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_event(input logic [2:0] op, input logic [3:0] hat,
                              input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, now, hat};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_status.insert(expected_status.size(), apply_timer_event(op, hat, now));
        events_sent++;
    endtask

    // Mostly short steps, sometimes long gaps that run the countdown out.
    function automatic logic [31:0] advance_clock();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: clock_ms = clock_ms + $urandom_range(1500);
            5, 6, 7:       clock_ms = clock_ms + $urandom_range(120000);
            8:             clock_ms = clock_ms + $urandom_range(1000000);
            default:       clock_ms = $urandom;
        endcase
        return clock_ms;
    endfunction

    function automatic logic [2:0] pick_button();
        case ($urandom_range(2))
            0:       return OP_START;
            1:       return OP_RESET;
            default: return OP_SETTING;
        endcase
    endfunction

    // Stops offering words, then waits until every expected word has come.
    task automatic wait_until_drained();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d status words never arrived",
                                      expected_status.size()));
    endtask

    task automatic run_countdown_sequence();
        int unsigned n;
        if (tm_focus != FOCUS_OFF && $urandom_range(1) == 1)
            send_event(OP_SETTING, 4'($urandom), advance_clock());
        send_event(OP_START, 4'($urandom), advance_clock());
        n = $urandom_range(8, 1);
        repeat (n) begin
            case ($urandom_range(19))
                0:       send_event(OP_START, 4'($urandom), advance_clock());
                1:       send_event(OP_RESET, 4'($urandom), advance_clock());
                2:       send_event(OP_HAT, 4'($urandom), advance_clock());
                default: send_event(OP_TICK, 4'($urandom), advance_clock());
            endcase
        end
        if (tm_alarm && $urandom_range(3) != 0)
            send_event(pick_button(), 4'($urandom), advance_clock());
    endtask

    task automatic edit_preset_sequence();
        int unsigned n;
        logic [3:0]  burst;
        if (tm_focus == FOCUS_OFF)
            send_event(OP_SETTING, 4'($urandom), advance_clock());
        n = $urandom_range(30, 1);
        burst = 4'(1 << $urandom_range(HAT_LEFT, HAT_UP));
        repeat (n) begin
            if ($urandom_range(4) == 0)
                send_event(OP_HAT, 4'($urandom_range(15)), advance_clock());
            else
                send_event(OP_HAT, burst, advance_clock());
        end
        if ($urandom_range(1) == 1)
            send_event(OP_SETTING, 4'($urandom), advance_clock());
    endtask

    task automatic test_idle_and_editing();
        send_event(OP_TICK, 4'b0000, 32'd0);
        send_event(OP_HAT, 4'b0001, 32'd10);
        send_event(OP_SPARE_FIRST, 4'b1111, 32'hFFFF_FFFF);
        send_event(OP_SETTING, 4'b0000, 32'd20);
        send_event(OP_HAT, 4'b0001, 32'd30);
        send_event(OP_HAT, 4'b0100, 32'd40);
        send_event(OP_HAT, 4'b0100, 32'd50);
        // All four bits at once: the preset returns to zero and focus comes back.
        send_event(OP_HAT, 4'b1111, 32'd60);
        send_event(OP_HAT, 4'b0010, 32'd70);
        send_event(OP_HAT, 4'b0010, 32'd80);
        send_event(OP_HAT, 4'b0010, 32'd90);
        send_event(OP_HAT, 4'b0001, 32'd100);
        send_event(OP_HAT, 4'b1000, 32'd110);
        send_event(OP_HAT, 4'b1000, 32'd120);
        send_event(OP_HAT, 4'b1000, 32'd130);
        send_event(OP_SETTING, 4'b0000, 32'd140);
    endtask

    task automatic test_countdown_and_alarm();
        send_event(OP_START, 4'b0000, 32'd1000);
        send_event(OP_SETTING, 4'b0000, 32'd1100);
        send_event(OP_HAT, 4'b0001, 32'd1200);
        send_event(OP_TICK, 4'b0000, 32'd1400);
        send_event(OP_START, 4'b0000, 32'd5000);
        send_event(OP_START, 4'b0000, 32'd6000);
        send_event(OP_TICK, 4'b0000, 32'd7000);
        send_event(OP_TICK, 4'b0000, 32'd8000);
        send_event(OP_HAT, 4'b0001, 32'd8100);
        send_event(OP_SPARE_LAST, 4'b0101, 32'd8200);
        send_event(OP_START, 4'b0000, 32'd8300);
    endtask

    task automatic test_alarm_dismissal();
        // Countdown across the wrap of the millisecond clock.
        send_event(OP_START, 4'b0000, 32'hFFFF_FF00);
        send_event(OP_TICK, 4'b0000, 32'h0000_0100);
        send_event(OP_TICK, 4'b0000, 32'h0000_0100);
        send_event(OP_TICK, 4'b0000, 32'h0000_02E8);
        send_event(OP_RESET, 4'b0000, 32'd900);
        send_event(OP_START, 4'b0000, 32'd1000);
        send_event(OP_TICK, 4'b0000, 32'd6000);
        send_event(OP_SETTING, 4'b0000, 32'd6100);
        // Pause exactly as the time runs out.
        send_event(OP_START, 4'b0000, 32'd7000);
        send_event(OP_START, 4'b0000, 32'd8000);
        // A zero preset expires on the first tick.
        send_event(OP_SETTING, 4'b0000, 32'd8100);
        send_event(OP_HAT, 4'b0100, 32'd8200);
        send_event(OP_SETTING, 4'b0000, 32'd8300);
        send_event(OP_START, 4'b0000, 32'd8400);
        send_event(OP_TICK, 4'b0000, 32'd8400);
        send_event(OP_RESET, 4'b0000, 32'd8500);
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 150;
        repeat (40)
            send_event(OP_TICK + 3'($urandom_range(OP_HAT)), 4'($urandom), advance_clock());
    endtask

    task automatic test_pause_until_drained();
        repeat (3) begin
            run_countdown_sequence();
            wait_until_drained();
            edit_preset_sequence();
        end
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
        int unsigned target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = events_sent + count;
        while (events_sent < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: run_countdown_sequence();
                5, 6, 7:       edit_preset_sequence();
                8:             send_event(3'($urandom_range(OP_SPARE_LAST)),
                                          4'($urandom), $urandom);
                default:       send_event(3'($urandom_range(OP_SPARE_LAST)),
                                          4'($urandom), advance_clock());
            endcase
        end
    endtask

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        clear_timer_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_editing();
        test_countdown_and_alarm();
        test_alarm_dismissal();
        test_output_stall();
        test_pause_until_drained();
        test_random_traffic(0, 0, 410);
        test_random_traffic(68, 0, 410);
        test_random_traffic(0, 68, 410);
        test_random_traffic(22, 22, 410);
        recv_stall_pct = 0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/cdt_pkg.sv
sv/cdt_core.sv
sv/cdt_disp.sv
sv/countdown_timer_controller.sv
verif/tb_countdown_timer_controller.sv
